### design/mgm_pkg.sv
// Shared types and constants of the minutiae greedy matcher.
`default_nettype none
package mgm_pkg;
	localparam int MaxPoints  = 64;
	localparam int CoordBits  = 12;
	localparam int AngleBits  = 10;
	localparam int DistBits   = 26;
	localparam int CfgBits    = 26;
	localparam int CountBits  = 7;
	localparam int ScoreBits  = 17;

	localparam logic [1:0] ModeLoad   = 2'd0;
	localparam logic [1:0] ModeProbe  = 2'd1;
	localparam logic [1:0] ModeFinish = 2'd2;

	localparam logic [1:0] RegDist    = 2'd0;
	localparam logic [1:0] RegAngle   = 2'd1;
	localparam logic [1:0] RegPermil  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_DIVIDE,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic load;
		logic drop;
		logic scan_start;
		logic scan_step;
		logic decide;
		logic div_start;
		logic div_step;
		logic report;
	} ctrl_cmd_t;

	typedef struct packed {
		logic store_full;
		logic probe_full;
		logic scan_last;
		logic div_last;
	} ctrl_stat_t;
endpackage
`default_nettype wire

### design/mgm_ctrl.sv
// Sequencer of the minutiae greedy matcher.
`default_nettype none
module mgm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         mode,
	input  wire mgm_pkg::ctrl_stat_t stat,
	output logic                    busy,
	output mgm_pkg::ctrl_cmd_t      cmd
);
	mgm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mgm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != mgm_pkg::ST_IDLE);
		case (state_q)
			mgm_pkg::ST_IDLE: begin
				if (start) begin
					case (mode)
						mgm_pkg::ModeLoad: begin
							if (stat.store_full) cmd.drop = 1'b1;
							else cmd.load = 1'b1;
						end
						mgm_pkg::ModeProbe: begin
							if (stat.probe_full) cmd.drop = 1'b1;
							else begin
								cmd.scan_start = 1'b1;
								state_d = mgm_pkg::ST_SCAN;
							end
						end
						mgm_pkg::ModeFinish: begin
							cmd.div_start = 1'b1;
							state_d = mgm_pkg::ST_DIVIDE;
						end
						default: ;
					endcase
				end
			end
			mgm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = mgm_pkg::ST_DRAIN;
			end
			mgm_pkg::ST_DRAIN: begin
				// last memory read lands here; fold it in
				cmd.scan_step = 1'b1;
				state_d = mgm_pkg::ST_DECIDE;
			end
			mgm_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = mgm_pkg::ST_IDLE;
			end
			mgm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = mgm_pkg::ST_REPORT;
			end
			mgm_pkg::ST_REPORT: begin
				cmd.report = 1'b1;
				state_d = mgm_pkg::ST_IDLE;
			end
			default: state_d = mgm_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### design/mgm_dp.sv
// Datapath of the minutiae greedy matcher: store, nearest scan and score.
`default_nettype none
module mgm_dp #(
	parameter int MAX_POINTS = mgm_pkg::MaxPoints,
	parameter int COORD_BITS = mgm_pkg::CoordBits
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mgm_pkg::ctrl_cmd_t              cmd,
	output mgm_pkg::ctrl_stat_t                  stat,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [mgm_pkg::CfgBits-1:0]     cfg_data,
	input  wire logic [COORD_BITS-1:0]           x_pos,
	input  wire logic [COORD_BITS-1:0]           y_pos,
	input  wire logic [mgm_pkg::AngleBits-1:0]   angle,
	output logic                                 done,
	output logic [mgm_pkg::CountBits-1:0]        matched_pairs,
	output logic [mgm_pkg::CountBits-1:0]        probe_count,
	output logic [mgm_pkg::CountBits-1:0]        ref_count,
	output logic [mgm_pkg::ScoreBits-1:0]        score_frac,
	output logic                                 is_match,
	output logic                                 overflow
);
	localparam int IdxBits = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CntBits = $clog2(MAX_POINTS + 1);
	localparam int PtBits  = 2 * COORD_BITS + mgm_pkg::AngleBits;
	localparam int SqBits  = 2 * COORD_BITS + 1;
	localparam int CmpBits = (SqBits > mgm_pkg::DistBits) ? SqBits : mgm_pkg::DistBits;
	localparam int CB      = mgm_pkg::CountBits;
	localparam int AB      = mgm_pkg::AngleBits;
	localparam int QBits   = mgm_pkg::ScoreBits;
	localparam int NumBits = CB + 16;

	logic [mgm_pkg::DistBits-1:0] dist_lim_q;
	logic [AB-1:0]                ang_lim_q;
	logic [AB-1:0]                permil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_lim_q <= mgm_pkg::DistBits'(400);
			ang_lim_q  <= AB'(86);
			permil_q   <= AB'(350);
		end else if (cfg_we) begin
			case (cfg_index)
				mgm_pkg::RegDist:   dist_lim_q <= cfg_data;
				mgm_pkg::RegAngle:  ang_lim_q  <= cfg_data[AB-1:0];
				mgm_pkg::RegPermil: permil_q   <= cfg_data[AB-1:0];
				default: ;
			endcase
		end
	end

	logic [PtBits-1:0]     mem [MAX_POINTS];
	logic [PtBits-1:0]     rd_s1;
	logic [MAX_POINTS-1:0] used_q;
	logic [CntBits-1:0]    ref_tot_q, probe_tot_q, pair_tot_q;
	logic                  drop_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [AB-1:0]         pa_q;
	logic [CntBits-1:0]    scan_q;
	logic                  rd_vld_s1;
	logic [IdxBits-1:0]    rd_idx_s1;
	logic                  found_q;
	logic [IdxBits-1:0]    best_q;
	logic [SqBits-1:0]     best_d_q;
	logic [AB-1:0]         best_a_q;

	always_ff @(posedge clk) begin
		if (cmd.load) mem[ref_tot_q[IdxBits-1:0]] <= {x_pos, y_pos, angle};
		rd_s1 <= mem[scan_q[IdxBits-1:0]];
	end

	// distance of the entry read last cycle
	logic [COORD_BITS-1:0] rx, ry, dx, dy;
	logic [AB-1:0]         ra, da;
	logic [SqBits-1:0]     d_cur;
	assign rx = rd_s1[PtBits-1 -: COORD_BITS];
	assign ry = rd_s1[AB +: COORD_BITS];
	assign ra = rd_s1[AB-1:0];
	assign dx = (px_q > rx) ? px_q - rx : rx - px_q;
	assign dy = (py_q > ry) ? py_q - ry : ry - py_q;
	assign d_cur = SqBits'(dx) * SqBits'(dx) + SqBits'(dy) * SqBits'(dy);
	always_comb begin
		da = (pa_q > best_a_q) ? pa_q - best_a_q : best_a_q - pa_q;
		if (da > AB'(512)) da = AB'(0) - da;
	end

	logic [CntBits-1:0] larger;
	assign larger = (probe_tot_q > ref_tot_q) ? probe_tot_q : ref_tot_q;

	// restoring divider, one quotient bit a cycle
	logic [NumBits-1:0] num_q;
	logic [CB:0]        rem_q;
	logic [QBits-1:0]   quo_q;
	logic [4:0]         dcnt_q;
	logic [CB+1:0]      trial;
	assign trial = {rem_q, num_q[NumBits-1]} - {2'b0, CB'(larger)};

	always_comb begin
		stat.store_full = (ref_tot_q >= CntBits'(MAX_POINTS));
		stat.probe_full = (probe_tot_q >= CntBits'(MAX_POINTS));
		stat.scan_last  = (scan_q + 1'b1 >= ref_tot_q) || (ref_tot_q == '0);
		stat.div_last   = (dcnt_q == 5'(NumBits - 1));
	end

	logic [CB+AB+1:0] lhs, rhs;
	assign lhs = (CB+AB+2)'(pair_tot_q) * (CB+AB+2)'(1000);
	assign rhs = (CB+AB+2)'(permil_q) * (CB+AB+2)'(larger);

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			px_q <= x_pos; py_q <= y_pos; pa_q <= angle;
		end
		if (rd_vld_s1 && !used_q[rd_idx_s1] && (!found_q || d_cur < best_d_q)) begin
			best_q <= rd_idx_s1; best_d_q <= d_cur; best_a_q <= ra;
		end
		if (cmd.div_start) begin
			num_q <= {CB'(pair_tot_q), 16'd0};
			rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			dcnt_q <= dcnt_q + 1'b1;
			if (!trial[CB+1]) begin
				rem_q <= trial[CB:0];
				quo_q <= {quo_q[QBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CB-1:0], num_q[NumBits-1]};
				quo_q <= {quo_q[QBits-2:0], 1'b0};
			end
		end
		if (cmd.report) begin
			matched_pairs <= CB'(pair_tot_q);
			probe_count   <= CB'(probe_tot_q);
			ref_count     <= CB'(ref_tot_q);
			score_frac    <= (larger == '0) ? '0 : quo_q;
			is_match      <= (larger != '0) && (lhs >= rhs);
			overflow      <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; ref_tot_q <= '0; probe_tot_q <= '0; pair_tot_q <= '0;
			drop_q <= 1'b0; scan_q <= '0; rd_vld_s1 <= 1'b0; rd_idx_s1 <= '0;
			found_q <= 1'b0; done <= 1'b0;
		end else begin
			done <= cmd.report;
			rd_vld_s1 <= cmd.scan_step && (scan_q < ref_tot_q);
			rd_idx_s1 <= scan_q[IdxBits-1:0];
			if (cmd.drop) drop_q <= 1'b1;
			if (cmd.load) begin
				used_q[ref_tot_q[IdxBits-1:0]] <= 1'b0;
				ref_tot_q <= ref_tot_q + 1'b1;
			end
			if (cmd.scan_start) begin
				probe_tot_q <= probe_tot_q + 1'b1;
				scan_q <= '0; found_q <= 1'b0;
			end else if (cmd.scan_step && scan_q < ref_tot_q) begin
				scan_q <= scan_q + 1'b1;
			end
			if (rd_vld_s1 && !used_q[rd_idx_s1]) found_q <= 1'b1;
			if (cmd.decide) begin
				if (found_q && CmpBits'(best_d_q) < CmpBits'(dist_lim_q)
					&& da < ang_lim_q) begin
					used_q[best_q] <= 1'b1;
					pair_tot_q <= pair_tot_q + 1'b1;
				end
			end
			if (cmd.report) begin
				used_q <= '0; ref_tot_q <= '0; probe_tot_q <= '0; pair_tot_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### design/minutiae_greedy_matcher.sv
// Top level of the minutiae greedy matcher.
// Load: stores one point, no result. Probe: scans the store for the nearest unused point,
// one stored point read per cycle from a single memory port, then decides on a pairing.
// Finish: the divider steps, then a report state; done is registered from the report state
// and pulses for one cycle. Results cannot be held off by the receiver.
// Asynchronous active-low reset clears counters and used bits; limits take their defaults.
`default_nettype none
module minutiae_greedy_matcher #(
	parameter int MAX_POINTS = mgm_pkg::MaxPoints,
	parameter int COORD_BITS = mgm_pkg::CoordBits
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [mgm_pkg::CfgBits-1:0]   cfg_data,
	input  wire logic [1:0]                    mode,
	input  wire logic [COORD_BITS-1:0]         x_pos,
	input  wire logic [COORD_BITS-1:0]         y_pos,
	input  wire logic [mgm_pkg::AngleBits-1:0] angle,
	output logic                               done,
	output logic [mgm_pkg::CountBits-1:0]      matched_pairs,
	output logic [mgm_pkg::CountBits-1:0]      probe_count,
	output logic [mgm_pkg::CountBits-1:0]      ref_count,
	output logic [mgm_pkg::ScoreBits-1:0]      score_frac,
	output logic                               is_match,
	output logic                               overflow
);
	mgm_pkg::ctrl_cmd_t  cmd;
	mgm_pkg::ctrl_stat_t stat;

	mgm_ctrl u_ctrl (.clk, .arst_n, .start, .mode, .stat, .busy, .cmd);

	mgm_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
		.x_pos, .y_pos, .angle, .done, .matched_pairs, .probe_count,
		.ref_count, .score_frac, .is_match, .overflow
	);
endmodule
`default_nettype wire

### design/mgm_checker.sv
// Port-level assertions for the minutiae greedy matcher, with bind.
`default_nettype none
module mgm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] mode,
	input wire logic       done,
	input wire logic [6:0] matched_pairs,
	input wire logic [6:0] probe_count,
	input wire logic [6:0] ref_count,
	input wire logic       is_match
);
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == mgm_pkg::ModeFinish |=> busy)
		else $error("finish not taken");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> matched_pairs <= probe_count && matched_pairs <= ref_count)
		else $error("too many pairs");
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		done && probe_count == 7'd0 && ref_count == 7'd0 |-> !is_match)
		else $error("match on empty sets");
endmodule

bind minutiae_greedy_matcher mgm_checker u_chk (
	.clk, .arst_n, .start, .busy, .mode, .done, .matched_pairs,
	.probe_count, .ref_count, .is_match
);
`default_nettype wire
